/* hdl/tepq_pkg.sv */
// Shared types and constants of the timed event priority queue.
// Depends on nothing; every other file but tepq_ram uses it by scoped names.
`timescale 1ns / 1ps
package tepq_pkg;

    // Request codes.
    localparam logic [2:0] FN_ADD        = 3'd0;
    localparam logic [2:0] FN_SERVICE    = 3'd1;
    localparam logic [2:0] FN_CANCEL_CLR = 3'd2;
    localparam logic [2:0] FN_CANCEL_TGT = 3'd3;
    localparam logic [2:0] FN_QUERY      = 3'd4;

    // At most this many events fire in one service request.
    localparam int unsigned RESULT_LIMIT = 32;
    localparam int unsigned FCW = $clog2(RESULT_LIMIT + 1);

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] now_time;
        logic [31:0] delay;
        logic [31:0] target_key;
        logic        target_is_entity;
        logic [31:0] input_hash;
        logic [15:0] activator_id;
        logic [15:0] caller_id;
        logic [31:0] output_id;
        logic [31:0] payload;
        logic        filter_by_activator;
    } in_item_t;

    typedef struct packed {
        logic        is_event;
        logic        flag;
        logic [31:0] ev_target_key;
        logic        ev_target_is_entity;
        logic [31:0] ev_input_hash;
        logic [15:0] ev_activator_id;
        logic [15:0] ev_caller_id;
        logic [31:0] ev_output_id;
        logic [31:0] ev_payload;
        logic        last;
    } out_item_t;

    // One stored event.
    typedef struct packed {
        logic [31:0] fire_time;
        logic [31:0] target;
        logic        target_kind;
        logic [31:0] input_hash;
        logic [15:0] activator;
        logic [15:0] caller;
        logic [31:0] output_id;
        logic [31:0] payload;
    } entry_t;

    // Verdict of the compare unit on one entry.
    typedef struct packed {
        logic keep;
        logic fire;
        logic stop;
        logic insert;
        logic hit;
    } dec_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

endpackage

/* hdl/tepq_in_if.sv */
// Request channel of the timed event priority queue.
// Depends on tepq_pkg for the beat type.
`timescale 1ns / 1ps
interface tepq_in_if;
    logic               valid;
    logic               ready;
    tepq_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/tepq_out_if.sv */
// Result channel of the timed event priority queue.
// Depends on tepq_pkg for the beat type.
`timescale 1ns / 1ps
interface tepq_out_if;
    logic                valid;
    logic                ready;
    tepq_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/tepq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module tepq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, and read port that holds its data while not enabled.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

/* hdl/tepq_match.sv */
// Shared compare unit: judges one stored entry against the current request.
// Depends on tepq_pkg.
`timescale 1ns / 1ps
module tepq_match (
    input  tepq_pkg::in_item_t cmd,
    input  logic [31:0]        fire_time,
    input  tepq_pkg::entry_t   ent,
    input  logic               firing,
    input  logic               limit_hit,
    input  logic               inserted,
    input  logic               full,
    output tepq_pkg::dec_t     dec
);
    logic tgt_eq;
    logic due;
    logic act_ok;

    assign tgt_eq = (cmd.target_key != 32'd0) && ent.target_kind &&
                    (ent.target == cmd.target_key);
    assign due    = ent.fire_time <= cmd.now_time;
    assign act_ok = !(cmd.filter_by_activator && (cmd.activator_id != 16'd0)) ||
                    (ent.activator == cmd.activator_id);

    // Decide keep, drop, fire, stop, insert or query hit for this entry.
    always_comb
    begin
        dec = '{keep: 1'b1, fire: 1'b0, stop: 1'b0, insert: 1'b0, hit: 1'b0};
        unique case (cmd.func)
            tepq_pkg::FN_ADD:
            begin
                dec.insert = !full && !inserted && (ent.fire_time > fire_time);
            end
            tepq_pkg::FN_SERVICE:
            begin
                if (firing)
                begin
                    if (!due)
                    begin
                        dec.stop = 1'b1;
                    end
                    else if (act_ok)
                    begin
                        if (limit_hit)
                        begin
                            dec.stop = 1'b1;
                        end
                        else
                        begin
                            dec.fire = 1'b1;
                            dec.keep = 1'b0;
                        end
                    end
                end
            end
            tepq_pkg::FN_CANCEL_CLR:
            begin
                dec.keep = !((cmd.caller_id != 16'd0) && (ent.caller == cmd.caller_id));
            end
            tepq_pkg::FN_CANCEL_TGT:
            begin
                dec.keep = !(tgt_eq && (ent.input_hash == cmd.input_hash));
            end
            tepq_pkg::FN_QUERY:
            begin
                dec.hit = tgt_eq && ((cmd.input_hash == 32'd0) ||
                                     (ent.input_hash == cmd.input_hash));
            end
            default:
            begin
                dec.keep = 1'b1;
            end
        endcase
    end
endmodule

/* hdl/timed_event_priority_queue_unit.sv */
// Timed event priority queue: sequencer, entry table and result register.
// Depends on tepq_pkg, tepq_in_if, tepq_out_if, tepq_ram and tepq_match.
//
// Usage: requests arrive as beats on in_ch and results leave on out_ch; both
// channels move a beat when valid and ready are high at a rising clock edge.
// The table holds up to DEPTH events sorted by fire time in one RAM.
// Every request walks the stored entries once through the shared compare
// unit, one entry per cycle while out_ch does not stall; entries that stay
// are written back compacted, an add carries the displaced entries one slot
// up as it goes. in_ch is not ready while a request is in progress.
// Add, cancel, query and a service that fires nothing return one beat with
// last set. A service returns one beat per fired event, the final one marked
// last. A stalled out_ch holds the result register and pauses the walk when a fired event awaits output.
// After reset the table is empty and in_ch is ready at once.
`timescale 1ns / 1ps
module timed_event_priority_queue_unit #(
    parameter int unsigned DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    tepq_in_if.sink     in_ch,
    tepq_out_if.source  out_ch
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned EW = $bits(tepq_pkg::entry_t);

    tepq_pkg::state_t    state_reg, state_next;
    tepq_pkg::in_item_t  cmd_reg, cmd_next;
    logic [31:0]         fire_reg, fire_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       wr_ptr_reg, wr_ptr_next;
    logic                rd_vld_reg, rd_vld_next;
    logic                firing_reg, firing_next;
    logic [tepq_pkg::FCW-1:0] fired_reg, fired_next;
    logic                inserted_reg, inserted_next;
    logic                found_reg, found_next;
    tepq_pkg::entry_t    carry_reg, carry_next;
    logic                pend_vld_reg, pend_vld_next;
    tepq_pkg::entry_t    pend_reg, pend_next;
    logic                out_vld_reg, out_vld_next;
    tepq_pkg::out_item_t out_reg, out_next;

    logic                ram_we, ram_re;
    logic [AW-1:0]       ram_waddr;
    tepq_pkg::entry_t    ram_wdata, ram_rdata;
    tepq_pkg::dec_t      dec;
    tepq_pkg::entry_t    new_ent;
    logic                full, out_free, stall, more;
    logic signed [33:0]  sum;
    logic [31:0]         sat;

    function automatic tepq_pkg::out_item_t make_event(tepq_pkg::entry_t e, logic lst);
        tepq_pkg::out_item_t o;
        o.is_event            = 1'b1;
        o.flag                = 1'b0;
        o.ev_target_key       = e.target;
        o.ev_target_is_entity = e.target_kind;
        o.ev_input_hash       = e.input_hash;
        o.ev_activator_id     = e.activator;
        o.ev_caller_id        = e.caller;
        o.ev_output_id        = e.output_id;
        o.ev_payload          = e.payload;
        o.last                = lst;
        return o;
    endfunction

    function automatic tepq_pkg::out_item_t make_ack(logic flg);
        tepq_pkg::out_item_t o;
        o      = '0;
        o.flag = flg;
        o.last = 1'b1;
        return o;
    endfunction

    tepq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    tepq_match u_match (
        .cmd       (cmd_reg),
        .fire_time (fire_reg),
        .ent       (ram_rdata),
        .firing    (firing_reg),
        .limit_hit (fired_reg == tepq_pkg::FCW'(tepq_pkg::RESULT_LIMIT)),
        .inserted  (inserted_reg),
        .full      (full),
        .dec       (dec)
    );

    // Saturating fire time of an incoming add.
    assign sum = $signed({2'b00, in_ch.data.now_time}) +
                 $signed({{2{in_ch.data.delay[31]}}, in_ch.data.delay});
    assign sat = sum[33] ? 32'd0 : (sum[32] ? 32'hFFFF_FFFF : sum[31:0]);

    assign full = count_reg >= CW'(DEPTH);

    // Event being added, built from the latched request.
    always_comb
    begin
        new_ent.fire_time   = fire_reg;
        new_ent.target      = cmd_reg.target_key;
        new_ent.target_kind = cmd_reg.target_is_entity;
        new_ent.input_hash  = cmd_reg.input_hash;
        new_ent.activator   = cmd_reg.activator_id;
        new_ent.caller      = cmd_reg.caller_id;
        new_ent.output_id   = cmd_reg.output_id;
        new_ent.payload     = cmd_reg.payload;
    end

    assign out_free = !out_vld_reg || out_ch.ready;
    assign more     = rd_ptr_reg < count_reg;
    assign stall    = rd_vld_reg && dec.fire && pend_vld_reg && !out_free;

    assign out_ch.valid = out_vld_reg;
    assign out_ch.data  = out_reg;

    // State and control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= tepq_pkg::ST_IDLE;
            count_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Working registers of the walk.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        fire_reg     <= fire_next;
        rd_ptr_reg   <= rd_ptr_next;
        wr_ptr_reg   <= wr_ptr_next;
        rd_vld_reg   <= rd_vld_next;
        firing_reg   <= firing_next;
        fired_reg    <= fired_next;
        inserted_reg <= inserted_next;
        found_reg    <= found_next;
        carry_reg    <= carry_next;
        pend_vld_reg <= pend_vld_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    // Sequencer: accept, walk the table, then deliver the closing beat.
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        fire_next     = fire_reg;
        count_next    = count_reg;
        rd_ptr_next   = rd_ptr_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_vld_next   = rd_vld_reg;
        firing_next   = firing_reg;
        fired_next    = fired_reg;
        inserted_next = inserted_reg;
        found_next    = found_reg;
        carry_next    = carry_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        out_next      = out_reg;
        out_vld_next  = out_vld_reg && !out_ch.ready;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = wr_ptr_reg[AW-1:0];
        ram_wdata     = ram_rdata;
        in_ch.ready   = 1'b0;

        unique case (state_reg)
            tepq_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_ch.valid)
                begin
                    cmd_next      = in_ch.data;
                    fire_next     = sat;
                    rd_ptr_next   = '0;
                    wr_ptr_next   = '0;
                    rd_vld_next   = 1'b0;
                    firing_next   = 1'b1;
                    fired_next    = '0;
                    inserted_next = 1'b0;
                    found_next    = 1'b0;
                    pend_vld_next = 1'b0;
                    state_next    = tepq_pkg::ST_SCAN;
                end
            end
            tepq_pkg::ST_SCAN:
            begin
                if (!stall)
                begin
                    // Fetch the next entry.
                    ram_re      = more;
                    rd_vld_next = more;
                    if (more)
                    begin
                        rd_ptr_next = rd_ptr_reg + CW'(1);
                    end
                    // Act on the entry already fetched into the RAM read data.
                    if (rd_vld_reg)
                    begin
                        if (dec.stop)
                        begin
                            firing_next = 1'b0;
                        end
                        if (dec.hit)
                        begin
                            found_next = 1'b1;
                        end
                        if (dec.fire)
                        begin
                            fired_next    = fired_reg + tepq_pkg::FCW'(1);
                            pend_next     = ram_rdata;
                            pend_vld_next = 1'b1;
                            if (pend_vld_reg)
                            begin
                                out_next     = make_event(pend_reg, 1'b0);
                                out_vld_next = 1'b1;
                            end
                        end
                        if (dec.insert)
                        begin
                            ram_we        = 1'b1;
                            ram_wdata     = new_ent;
                            carry_next    = ram_rdata;
                            inserted_next = 1'b1;
                            wr_ptr_next   = wr_ptr_reg + CW'(1);
                        end
                        else if (dec.keep)
                        begin
                            ram_we      = 1'b1;
                            ram_wdata   = inserted_reg ? carry_reg : ram_rdata;
                            carry_next  = ram_rdata;
                            wr_ptr_next = wr_ptr_reg + CW'(1);
                        end
                    end
                    if (!more && !rd_vld_reg)
                    begin
                        state_next = tepq_pkg::ST_FINISH;
                    end
                end
            end
            tepq_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    if ((cmd_reg.func == tepq_pkg::FN_SERVICE) && pend_vld_reg)
                    begin
                        out_next = make_event(pend_reg, 1'b1);
                    end
                    else if (cmd_reg.func == tepq_pkg::FN_ADD)
                    begin
                        out_next = make_ack(full);
                    end
                    else if (cmd_reg.func == tepq_pkg::FN_QUERY)
                    begin
                        out_next = make_ack(found_reg);
                    end
                    else
                    begin
                        out_next = make_ack(1'b0);
                    end
                    // Tail write of an add, and the new fill count.
                    if ((cmd_reg.func == tepq_pkg::FN_ADD) && !full)
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = inserted_reg ? carry_reg : new_ent;
                        count_next = wr_ptr_reg + CW'(1);
                    end
                    else
                    begin
                        count_next = wr_ptr_reg;
                    end
                    state_next = tepq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tepq_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
